// ===== sv/gic_pkg.sv =====
`timescale 1ns / 1ps

package gic_pkg;

  localparam int PixW         = 8;
  localparam int CoefW        = 12;
  localparam int CoefRowW     = 60;
  localparam int NumCoefRows  = 5;
  localparam int LineWidthW   = 11;
  localparam int FrameHeightW = 16;
  // unsigned pixel widened by one sign bit times a signed coefficient
  localparam int ProdW        = PixW + 1 + CoefW;
  localparam int ApbAddrW     = 6;
  localparam int ApbDataW     = 64;

  localparam logic [LineWidthW-1:0]   LineWidthReset   = 11'd1024;
  localparam logic [FrameHeightW-1:0] FrameHeightReset = 16'd1024;
  localparam logic [CoefRowW-1:0]     CoefRowZero      = 60'h0;
  // unity weight (1.0 in Q3.8) on the middle column of a 3 wide kernel
  localparam logic [CoefRowW-1:0]     CoefRowCentre    = 60'h100000;

  typedef logic [CoefRowW-1:0] coef_row_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_ROW_0   = 3'd2,
    REG_COEF_ROW_1   = 3'd3,
    REG_COEF_ROW_2   = 3'd4,
    REG_COEF_ROW_3   = 3'd5,
    REG_COEF_ROW_4   = 3'd6
  } reg_idx_e;

  // item held in the input register
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic is_edge;
  } s0_ctl_t;

  // control travelling with a result through the arithmetic stages
  typedef struct packed {
    logic valid;
    logic last;
    logic is_edge;
  } stage_t;

endpackage

// ===== sv/gic_cfg.sv =====
`timescale 1ns / 1ps

module gic_cfg (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              psel,
  input  logic                                              penable,
  input  logic                                              pwrite,
  input  logic [gic_pkg::ApbAddrW-1:0]                      paddr,
  input  logic [gic_pkg::ApbDataW-1:0]                      pwdata,
  output logic [gic_pkg::ApbDataW-1:0]                      prdata,
  output logic                                              pready,
  output logic [gic_pkg::LineWidthW-1:0]                    line_width_o,
  output logic [gic_pkg::FrameHeightW-1:0]                  frame_height_o,
  output gic_pkg::coef_row_t [gic_pkg::NumCoefRows-1:0]     coef_rows_o
);
  import gic_pkg::*;

  logic [LineWidthW-1:0]   line_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  coef_row_t [NumCoefRows-1:0] coef_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthReset;
      frame_height_q <= FrameHeightReset;
      coef_q[0]      <= CoefRowZero;
      coef_q[1]      <= CoefRowCentre;
      coef_q[2]      <= CoefRowZero;
      coef_q[3]      <= CoefRowZero;
      coef_q[4]      <= CoefRowZero;
    end else if (wr) begin
      unique case (idx)
        REG_LINE_WIDTH:   line_width_q   <= pwdata[LineWidthW-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[FrameHeightW-1:0];
        REG_COEF_ROW_0:   coef_q[0]      <= pwdata[CoefRowW-1:0];
        REG_COEF_ROW_1:   coef_q[1]      <= pwdata[CoefRowW-1:0];
        REG_COEF_ROW_2:   coef_q[2]      <= pwdata[CoefRowW-1:0];
        REG_COEF_ROW_3:   coef_q[3]      <= pwdata[CoefRowW-1:0];
        REG_COEF_ROW_4:   coef_q[4]      <= pwdata[CoefRowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LINE_WIDTH:   prdata = ApbDataW'(line_width_q);
      REG_FRAME_HEIGHT: prdata = ApbDataW'(frame_height_q);
      REG_COEF_ROW_0:   prdata = ApbDataW'(coef_q[0]);
      REG_COEF_ROW_1:   prdata = ApbDataW'(coef_q[1]);
      REG_COEF_ROW_2:   prdata = ApbDataW'(coef_q[2]);
      REG_COEF_ROW_3:   prdata = ApbDataW'(coef_q[3]);
      REG_COEF_ROW_4:   prdata = ApbDataW'(coef_q[4]);
      default:          prdata = '0;
    endcase
  end

  assign line_width_o   = line_width_q;
  assign frame_height_o = frame_height_q;
  assign coef_rows_o    = coef_q;

endmodule

// ===== sv/gic_ctrl.sv =====
`timescale 1ns / 1ps

module gic_ctrl #(
  parameter  int KERNEL_SIZE = 3,
  parameter  int MAX_WIDTH   = 1024,
  localparam int ColW        = $clog2(MAX_WIDTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 s_valid_i,
  output logic                                 s_ready_o,
  input  gic_pkg::kind_e                       kind_i,
  input  logic [gic_pkg::PixW-1:0]             pix_i,
  input  logic [gic_pkg::LineWidthW-1:0]       line_width_i,
  input  logic [gic_pkg::FrameHeightW-1:0]     frame_height_i,
  output gic_pkg::s0_ctl_t                     s0_ctl_o,
  output logic [gic_pkg::PixW-1:0]             s0_pix_o,
  output logic [ColW-1:0]                      s0_col_o,
  output logic                                 rd_en_o,
  output logic [ColW-1:0]                      rd_addr_o
);
  import gic_pkg::*;

  localparam int KR   = KERNEL_SIZE / 2;
  localparam int GeoW = $clog2(MAX_WIDTH + 1);
  localparam int CmpW = (GeoW > LineWidthW) ? GeoW : LineWidthW;
  localparam int LagW = $clog2(KR * MAX_WIDTH + KR + 1);
  localparam int HW   = FrameHeightW;

  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HW-1:0]   in_row_q, in_row_d, out_row_q, out_row_d;
  logic [GeoW-1:0] geo_w_q, geo_w_d;
  logic [HW-1:0]   geo_h_q, geo_h_d;
  logic [LagW-1:0] lag_q, lag_d, thr_q, thr_d;
  logic            rx_done_q, rx_done_d;

  s0_ctl_t         s0_ctl_q;
  logic [PixW-1:0] s0_pix_q;
  logic [ColW-1:0] s0_col_q;

  logic [CmpW-1:0] lw_ext;
  logic [GeoW-1:0] w_new, w_eff;
  logic [HW-1:0]   h_new, h_eff;
  logic [LagW-1:0] thr_new, thr_eff;
  logic            catch_up, ready, accept, start, real_push;
  logic            load, do_emit, col_last, in_row_last, frame_last, is_edge;

  always_comb begin
    lw_ext = CmpW'(line_width_i);
    if (lw_ext == '0) begin
      w_new = GeoW'(1);
    end else if (lw_ext > CmpW'(MAX_WIDTH)) begin
      w_new = GeoW'(MAX_WIDTH);
    end else begin
      w_new = GeoW'(lw_ext);
    end
    h_new   = (frame_height_i == '0) ? HW'(1) : frame_height_i;
    thr_new = LagW'(KR) * LagW'(w_new) + LagW'(KR);

    // frames shorter than the window delay need the line stores topped up
    catch_up  = rx_done_q && (lag_q != thr_q);
    ready     = en_i && !catch_up;
    accept    = s_valid_i && ready;
    start     = accept && (kind_i == KIND_PIXEL) && (in_row_q == '0) && (in_col_q == '0) &&
                (out_row_q == '0) && (out_col_q == '0);
    w_eff     = start ? w_new : geo_w_q;
    h_eff     = start ? h_new : geo_h_q;
    thr_eff   = start ? thr_new : thr_q;
    real_push = (kind_i == KIND_PIXEL) && !rx_done_q;

    load    = (accept && (real_push || rx_done_q)) || (catch_up && en_i);
    do_emit = accept && (rx_done_q || (real_push && (lag_q >= thr_eff)));

    col_last    = ((GeoW'(in_col_q) + GeoW'(1)) == w_eff);
    in_row_last = (({1'b0, in_row_q} + (HW + 1)'(1)) == {1'b0, h_eff});
    frame_last  = ((GeoW'(out_col_q) + GeoW'(1)) == w_eff) &&
                  (({1'b0, out_row_q} + (HW + 1)'(1)) == {1'b0, h_eff});
    is_edge     = (out_row_q < HW'(KR)) ||
                  (({1'b0, out_row_q} + (HW + 1)'(KR)) >= {1'b0, h_eff}) ||
                  (out_col_q < ColW'(KR)) ||
                  (((GeoW + 1)'(out_col_q) + (GeoW + 1)'(KR)) >= (GeoW + 1)'(w_eff));

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lag_d     = lag_q;
    rx_done_d = rx_done_q;
    geo_w_d   = geo_w_q;
    geo_h_d   = geo_h_q;
    thr_d     = thr_q;

    if (start) begin
      geo_w_d = w_new;
      geo_h_d = h_new;
      thr_d   = thr_new;
    end
    if (load) begin
      in_col_d = col_last ? '0 : in_col_q + ColW'(1);
      if (!do_emit) begin
        lag_d = lag_q + LagW'(1);
      end
    end
    if (accept && real_push && col_last) begin
      in_row_d = in_row_q + HW'(1);
      if (in_row_last) begin
        rx_done_d = 1'b1;
      end
    end
    if (do_emit) begin
      if ((GeoW'(out_col_q) + GeoW'(1)) == w_eff) begin
        out_col_d = '0;
        out_row_d = out_row_q + HW'(1);
      end else begin
        out_col_d = out_col_q + ColW'(1);
      end
      if (frame_last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        lag_d     = '0;
        rx_done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lag_q     <= '0;
      rx_done_q <= 1'b0;
      geo_w_q   <= GeoW'(1024);
      geo_h_q   <= HW'(1024);
      thr_q     <= LagW'(KR) * LagW'(1024) + LagW'(KR);
      s0_ctl_q  <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
      rx_done_q <= rx_done_d;
      geo_w_q   <= geo_w_d;
      geo_h_q   <= geo_h_d;
      thr_q     <= thr_d;
      if (en_i) begin
        s0_ctl_q.valid <= load;
      end
      if (load) begin
        s0_ctl_q.emit    <= do_emit;
        s0_ctl_q.last    <= do_emit && frame_last;
        s0_ctl_q.is_edge <= is_edge;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s0_pix_q <= pix_i;
      s0_col_q <= in_col_q;
    end
  end

  assign s_ready_o = ready;
  assign s0_ctl_o  = s0_ctl_q;
  assign s0_pix_o  = s0_pix_q;
  assign s0_col_o  = s0_col_q;
  assign rd_en_o   = load;
  assign rd_addr_o = in_col_q;

endmodule

// ===== sv/gic_line_buf.sv =====
`timescale 1ns / 1ps

module gic_line_buf #(
  parameter  int KERNEL_SIZE = 3,
  parameter  int MAX_WIDTH   = 1024,
  localparam int ColW        = $clog2(MAX_WIDTH),
  localparam int LaneW       = (KERNEL_SIZE - 1) * gic_pkg::PixW
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [ColW-1:0]          rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [ColW-1:0]          wr_addr_i,
  input  logic [gic_pkg::PixW-1:0] wr_pix_i,
  output logic [LaneW-1:0]         lanes_o
);
  import gic_pkg::*;

  // one entry per column, lane l holds the pixel l+1 lines above
  logic [LaneW-1:0] mem_q [MAX_WIDTH];
  logic [LaneW-1:0] lanes_q;
  logic [LaneW-1:0] wr_data;

  assign wr_data = {lanes_q[LaneW-PixW-1:0], wr_pix_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data;
    end
    if (rd_en_i) begin
      // one pixel per line: the column just written is read straight back
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        lanes_q <= wr_data;
      end else begin
        lanes_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign lanes_o = lanes_q;

endmodule

// ===== sv/gic_mac.sv =====
`timescale 1ns / 1ps

module gic_mac #(
  parameter  int KERNEL_SIZE = 3,
  localparam int LaneW       = (KERNEL_SIZE - 1) * gic_pkg::PixW
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  gic_pkg::s0_ctl_t                              s0_ctl_i,
  input  logic [gic_pkg::PixW-1:0]                      s0_pix_i,
  input  logic [LaneW-1:0]                              lanes_i,
  input  gic_pkg::coef_row_t [gic_pkg::NumCoefRows-1:0] coef_rows_i,
  input  logic                                          m_ready_i,
  output logic                                          en_o,
  output logic                                          m_valid_o,
  output logic [gic_pkg::PixW-1:0]                      m_data_o,
  output logic                                          m_last_o
);
  import gic_pkg::*;

  localparam int K    = KERNEL_SIZE;
  localparam int KR   = K / 2;
  localparam int RowW = ProdW + $clog2(K);
  localparam int SumW = RowW + $clog2(K);
  localparam int QuoW = SumW - PixW;

  logic [PixW-1:0]         win_q   [K][K];
  logic [PixW-1:0]         col_new [K];
  logic signed [ProdW-1:0] prod_d  [K*K];
  logic signed [ProdW-1:0] prod_q  [K*K];
  logic signed [RowW-1:0]  row_d   [K];
  logic signed [RowW-1:0]  row_q   [K];
  logic signed [SumW-1:0]  sum_d;
  logic [QuoW-1:0]         quo;
  logic [PixW-1:0]         sat;
  logic [PixW-1:0]         ctr2_q, ctr3_q, out_pix_q;
  logic                    out_last_q, out_v_q;
  stage_t                  st1_q, st2_q, st3_q;
  logic                    en;

  assign en = !out_v_q || m_ready_i;

  // newest column: bottom row is the incoming pixel, the rest from the line store
  always_comb begin
    for (int i = 0; i < K - 1; i++) begin
      col_new[i] = lanes_i[(K - 2 - i) * PixW +: PixW];
    end
    col_new[K-1] = s0_pix_i;
  end

  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        prod_d[i*K+j] = $signed({1'b0, win_q[i][j]}) *
                        $signed(coef_rows_i[i][j*CoefW +: CoefW]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < K; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < K; j++) begin
        row_d[i] = row_d[i] + RowW'(prod_q[i*K+j]);
      end
    end
  end

  // negative sums round towards minus infinity and clamp to zero anyway
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < K; i++) begin
      sum_d = sum_d + SumW'(row_q[i]);
    end
    quo = sum_d[SumW-1:PixW];
    if (sum_d[SumW-1]) begin
      sat = '0;
    end else if (|quo[QuoW-1:PixW]) begin
      sat = '1;
    end else begin
      sat = quo[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q   <= '0;
      st2_q   <= '0;
      st3_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      st1_q.valid   <= s0_ctl_i.valid && s0_ctl_i.emit;
      st1_q.last    <= s0_ctl_i.last;
      st1_q.is_edge <= s0_ctl_i.is_edge;
      st2_q         <= st1_q;
      st3_q         <= st2_q;
      out_v_q       <= st3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s0_ctl_i.valid) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K - 1; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
        win_q[i][K-1] <= col_new[i];
      end
    end
    if (en) begin
      prod_q     <= prod_d;
      ctr2_q     <= win_q[KR][KR];
      row_q      <= row_d;
      ctr3_q     <= ctr2_q;
      out_pix_q  <= st3_q.is_edge ? ctr3_q : sat;
      out_last_q <= st3_q.last;
    end
  end

  assign en_o      = en;
  assign m_valid_o = out_v_q;
  assign m_data_o  = out_pix_q;
  assign m_last_o  = out_last_q;

endmodule

// ===== sv/grey_image_convolution.sv =====
`timescale 1ns / 1ps
// the input word that completes a window passes the input, window, product, row-sum and
// output registers; throughput: one word per cycle unless the output stalls; results trail
// the input by R*W+R pixels (R = KERNEL_SIZE/2); a frame of fewer than R*W+R+1 pixels holds
// tready low after its last pixel to top up the line store before its trailing edge pixels drain
// reset (async, active low): counters and valids cleared, geometry 1024 x 1024, centre tap 1.0;
// line store contents are not cleared

module grey_image_convolution #(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] pixel_value
  input  logic [0:0]                      s_axis_tuser,  // [0] kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] out_pixel
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gic_pkg::ApbAddrW-1:0]    paddr,
  input  logic [gic_pkg::ApbDataW-1:0]    pwdata,
  output logic [gic_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import gic_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int LaneW = (KERNEL_SIZE - 1) * PixW;

  logic [LineWidthW-1:0]       line_width;
  logic [FrameHeightW-1:0]     frame_height;
  coef_row_t [NumCoefRows-1:0] coef_rows;
  s0_ctl_t                     s0_ctl;
  logic [PixW-1:0]             s0_pix;
  logic [ColW-1:0]             s0_col, rd_addr;
  logic                        rd_en, en;
  logic [LaneW-1:0]            lanes;

  gic_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .line_width_o   (line_width),
    .frame_height_o (frame_height),
    .coef_rows_o    (coef_rows)
  );

  gic_ctrl #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .kind_i         (kind_e'(s_axis_tuser[0])),
    .pix_i          (s_axis_tdata),
    .line_width_i   (line_width),
    .frame_height_i (frame_height),
    .s0_ctl_o       (s0_ctl),
    .s0_pix_o       (s0_pix),
    .s0_col_o       (s0_col),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr)
  );

  gic_line_buf #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s0_ctl.valid && en),
    .wr_addr_i (s0_col),
    .wr_pix_i  (s0_pix),
    .lanes_o   (lanes)
  );

  gic_mac #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s0_ctl_i    (s0_ctl),
    .s0_pix_i    (s0_pix),
    .lanes_i     (lanes),
    .coef_rows_i (coef_rows),
    .m_ready_i   (m_axis_tready),
    .en_o        (en),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

  // no word taken while a finished result is stuck at the output
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while the output stage is stalled");

  // the last pixel of a frame lies on the border and is always a copy
  a_last_is_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_ctl.valid && s0_ctl.emit && s0_ctl.last) |-> s0_ctl.is_edge)
    else $error("frame end flagged on an interior pixel");

  // a stalled input register keeps its word for the line store write
  a_s0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && s0_ctl.valid) |=> (s0_ctl.valid && $stable(s0_pix) && $stable(s0_col)))
    else $error("input register changed while stalled");

endmodule
